// ----- hdl/nbh_pkg.sv -----
`default_nettype none
package nbh_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned EC_W    = 9;
  localparam int unsigned CFG_AW  = 3;

  localparam logic REG_EDGE_COUNT = 1'b0;
  localparam logic [EC_W-1:0] EDGE_COUNT_RST = 9'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_BIN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } nbh_op_t;

  typedef struct packed {
    nbh_op_t                   op;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;
  } nbh_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bin;
    logic               hit;
    logic [DATA_W-1:0]  count;
  } nbh_res_t;

endpackage
`default_nettype wire

// ----- hdl/nbh_ram.sv -----
`default_nettype none
module nbh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/nbh_seq.sv -----
`default_nettype none
module nbh_seq
  import nbh_pkg::*;
#(
  parameter int unsigned MAX_EDGES   = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire nbh_item_t       item,
  input  wire logic [EC_W-1:0] edge_count,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output nbh_res_t             res
);

  localparam int unsigned AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CDEPTH = MAX_EDGES - 1;
  localparam int unsigned CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int unsigned NW     = $clog2(MAX_EDGES + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOAD, S_RD, S_RDW, S_LO, S_HI, S_RANGE, S_SRCH, S_BIN, S_CW, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CAW-1:0]           clr_r, clr_nxt;
  logic [INDEX_W-1:0]       idx_r, idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [NW-1:0]            n_r, n_nxt;
  logic [NW-1:0]            first_r, first_nxt;
  logic [NW-1:0]            cnt_r, cnt_nxt;
  logic [NW-1:0]            bin_r, bin_nxt;
  logic                     lo_ok_r, lo_ok_nxt;
  nbh_res_t                 res_r, res_nxt;

  logic                     e_we;
  logic [AW-1:0]            e_raddr;
  logic [DATA_W-1:0]        e_rdata;
  logic signed [DATA_W-1:0] e_val;
  logic                     c_we;
  logic [CAW-1:0]           c_waddr, c_raddr;
  logic [COUNT_WIDTH-1:0]   c_wdata, c_rdata, c_inc;
  logic [NW-1:0]            step, at, srch_addr, b_pre, b_lim, b_sel;
  logic [NW-1:0]            n_clamp;
  logic [31:0]              ec_ext;
  logic                     load_ok, read_ok;

  nbh_ram #(.WIDTH(DATA_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .wr_en   (e_we),
    .wr_addr (AW'(idx_r)),
    .wr_data (val_r),
    .rd_addr (e_raddr),
    .rd_data (e_rdata)
  );

  nbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CDEPTH)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (c_wdata),
    .rd_addr (c_raddr),
    .rd_data (c_rdata)
  );

  assign e_val   = signed'(e_rdata);
  assign ec_ext  = 32'(edge_count);
  assign n_clamp = (ec_ext < 32'd2) ? NW'(2) :
                   (ec_ext > 32'(MAX_EDGES)) ? NW'(MAX_EDGES) : NW'(ec_ext);
  assign load_ok = 32'(idx_r) < 32'(MAX_EDGES);
  assign read_ok = 32'(idx_r) < 32'(CDEPTH);

  assign step  = cnt_r >> 1;
  assign at    = first_r + step;
  assign b_pre = (first_r == '0) ? '0 : first_r - NW'(1);
  assign b_lim = n_r - NW'(2);
  assign b_sel = (b_pre > b_lim) ? b_lim : b_pre;
  assign c_inc = (c_rdata == '1) ? c_rdata : c_rdata + COUNT_WIDTH'(1);

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res        = res_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    n_nxt     = n_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    bin_nxt   = bin_r;
    lo_ok_nxt = lo_ok_r;
    res_nxt   = res_r;
    e_we      = 1'b0;
    c_we      = 1'b0;
    c_waddr   = bin_r[CAW-1:0];
    c_wdata   = c_inc;
    c_raddr   = CAW'(idx_r);
    case (state_r)
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        c_wdata = '0;
        clr_nxt = clr_r + CAW'(1);
        if (clr_r == CAW'(CDEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          idx_nxt = item.index;
          val_nxt = item.value;
          n_nxt   = n_clamp;
          case (item.op)
            OP_LOAD: state_nxt = S_LOAD;
            OP_BIN:  state_nxt = S_LO;
            OP_READ: state_nxt = S_RD;
            default: begin
              res_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LOAD: begin
        e_we      = load_ok;
        res_nxt   = '{bin: idx_r, hit: 1'b0, count: '0};
        state_nxt = S_DONE;
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_nxt   = '{bin: idx_r, hit: 1'b0,
                      count: read_ok ? DATA_W'(c_rdata) : '0};
        state_nxt = S_DONE;
      end
      S_LO: begin
        state_nxt = S_HI;
      end
      S_HI: begin
        lo_ok_nxt = (val_r >= e_val);
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        first_nxt = '0;
        cnt_nxt   = n_r;
        if (lo_ok_r && (val_r < e_val)) begin
          state_nxt = S_SRCH;
        end else begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_SRCH: begin
        if (!(val_r < e_val)) begin
          first_nxt = at + NW'(1);
          cnt_nxt   = cnt_r - step - NW'(1);
        end else begin
          cnt_nxt = step;
        end
        if (cnt_nxt == '0) begin
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        c_raddr   = CAW'(b_sel);
        bin_nxt   = b_sel;
        state_nxt = S_CW;
      end
      S_CW: begin
        c_we      = 1'b1;
        res_nxt   = '{bin: INDEX_W'(bin_r), hit: 1'b1, count: DATA_W'(c_inc)};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign srch_addr = first_nxt + (cnt_nxt >> 1);

  always_comb begin
    case (state_r)
      S_HI:            e_raddr = AW'(n_r - NW'(1));
      S_RANGE, S_SRCH: e_raddr = AW'(srch_addr);
      default:         e_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    bin_r   <= bin_nxt;
    lo_ok_r <= lo_ok_nxt;
    res_r   <= res_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/nonuniform_bin_histogram_core.sv -----
// From input transfer to out_tvalid: edge load S_LOAD; counter read S_RD, S_RDW;
// sample S_LO, S_HI, S_RANGE, upper-bound search steps in S_SRCH (each one read of
// the edge memory), S_BIN, S_CW, or from S_RANGE out of range; OP_NONE: none of these;
// then S_DONE and the output register. One item at a time: the next input waits
// for the result to leave S_DONE. Reset: synchronous, active low; edge_count
// returns to 2; clearing the MAX_EDGES-1 counter entries then holds in_tready low.
`default_nettype none
module nonuniform_bin_histogram_core
  import nbh_pkg::*;
#(
  parameter int unsigned MAX_EDGES   = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,    // index[7:0], value[39:8]
  input  wire logic [1:0]        in_tuser,    // op[1:0]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,   // bin[7:0], count[39:8]
  output logic                   out_tuser,   // hit
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [EC_W-1:0] edge_count_r;
  logic            out_valid_r, out_valid_nxt;
  nbh_res_t        out_res_r, out_res_nxt;
  nbh_item_t       item;
  nbh_res_t        seq_res;
  logic            seq_res_valid, seq_res_ready;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_EDGE_COUNT) ? 32'(edge_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= EDGE_COUNT_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_EDGE_COUNT)) begin
      edge_count_r <= cfg_pwdata[EC_W-1:0];
    end
  end

  assign item.op    = nbh_op_t'(in_tuser);
  assign item.index = in_tdata[7:0];
  assign item.value = signed'(in_tdata[39:8]);

  nbh_seq #(.MAX_EDGES(MAX_EDGES), .COUNT_WIDTH(COUNT_WIDTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .edge_count (edge_count_r),
    .res_valid  (seq_res_valid),
    .res_ready  (seq_res_ready),
    .res        (seq_res)
  );

  assign seq_res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (seq_res_valid && seq_res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = seq_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.count, out_res_r.bin};
  assign out_tuser  = out_res_r.hit;

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_hold_during_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during counter clearing");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    seq_res_valid && seq_res_ready |=> out_tvalid)
    else $error("result lost before output register");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_wr && (cfg_paddr[2] == REG_EDGE_COUNT)
      |=> edge_count_r == $past(cfg_pwdata[EC_W-1:0]))
    else $error("edge_count write not taken");
`endif

endmodule
`default_nettype wire
